@@ rtl/core/tshu_pkg.sv @@
// tshu_pkg: command, status and op codes and the op record that travels
// from the front end through the queue to the back end of the sample history.
// No dependencies.
`default_nettype none

package tshu_pkg;

    // input command codes
    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_DUMP = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    // classified op kinds
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_STAT = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_DUMP = 2'd3;

    // field widths sized for the largest supported ring (64 entries)
    localparam int C_PTR_W = 6;
    localparam int C_CNT_W = 7;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         status;
        logic               wrap;
        logic [C_PTR_W-1:0] addr;
        logic [C_CNT_W-1:0] count;
        logic [31:0]        value;
        logic [31:0]        stamp;
    } t_op;

endpackage

`default_nettype wire

@@ rtl/core/tshu_ram.sv @@
// tshu_ram: generic single-port-write, single-port-read RAM with registered
// read data that holds while no read is issued. No dependencies.
`default_nettype none

module tshu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/tshu_front.sv @@
// tshu_front: accepts input items, checks kind and fill, resolves ring
// addresses and pushes one op per item of a known command. Holds the
// config register, write position and fill level. Depends on tshu_pkg.
`default_nettype none

module tshu_front import tshu_pkg::*; #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic        i_value_kind,
    input  wire logic [31:0] i_sample_value,
    input  wire logic [31:0] i_timestamp,
    input  wire logic [15:0] i_count_requested,
    input  wire logic        i_q_full,
    output logic             o_push,
    output t_op              o_op
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(RING_DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] DEPTH_F = FW'(RING_DEPTH);

    logic          r_kind_setting;
    logic [AW-1:0] r_wp;
    logic [FW-1:0] r_fill;
    logic [AW-1:0] n_wp;
    logic [FW-1:0] n_fill;

    logic          accept;
    logic          kind_ok;
    logic          empty;
    logic [15:0]   fill_16;
    logic          read_all;
    logic          dump_all;
    logic [FW-1:0] span;
    logic [SW-1:0] back_sum;
    logic [AW-1:0] back_addr;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign kind_ok = (i_value_kind == r_kind_setting);
    assign empty   = (r_fill == '0);
    assign fill_16 = 16'(r_fill);

    // clamp of the requested count to the fill level
    assign read_all = (i_count_requested == 16'd0) || (i_count_requested > fill_16);
    assign dump_all = (i_count_requested == 16'd0) || (i_count_requested >= fill_16);

    always_comb begin
        if (i_command == CMD_READ) begin
            span = read_all ? r_fill : i_count_requested[FW-1:0];
        end else begin
            span = dump_all ? r_fill : i_count_requested[FW-1:0];
        end
    end

    // position span entries behind the write position, modulo ring depth
    assign back_sum  = SW'(r_wp) + DEPTH_S - SW'(span);
    assign back_addr = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);

    // classify the item
    always_comb begin
        o_push       = 1'b0;
        o_op.kind    = OP_STAT;
        o_op.status  = ST_OK;
        o_op.wrap    = 1'b0;
        o_op.addr    = C_PTR_W'(back_addr);
        o_op.count   = C_CNT_W'(span);
        o_op.value   = i_sample_value;
        o_op.stamp   = i_timestamp;
        n_wp         = r_wp;
        n_fill       = r_fill;
        unique case (i_command)
            CMD_ADD: begin
                o_push = accept;
                if (!kind_ok) begin
                    o_op.status = ST_MISMATCH;
                end else begin
                    o_op.kind = OP_ADD;
                    o_op.addr = C_PTR_W'(r_wp);
                    o_op.wrap = (r_wp == LAST_POS);
                    if (accept) begin
                        n_wp = (r_wp == LAST_POS) ? '0 : r_wp + 1'b1;
                        if (r_fill != DEPTH_F) begin
                            n_fill = r_fill + 1'b1;
                        end
                    end
                end
            end
            CMD_READ: begin
                o_push = accept;
                if (!kind_ok) begin
                    o_op.status = ST_MISMATCH;
                end else if (empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    o_op.kind  = OP_READ;
                    o_op.count = C_CNT_W'(1);
                end
            end
            CMD_DUMP: begin
                o_push = accept;
                if (empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    o_op.kind = OP_DUMP;
                end
            end
            default: begin
                // unused command: taken and dropped
                o_push = 1'b0;
            end
        endcase
    end

    // config register and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind_setting <= 1'b0;
            r_wp           <= '0;
            r_fill         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_kind_setting <= i_cfg_wdata;
            end
            r_wp   <= n_wp;
            r_fill <= n_fill;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tshu_queue.sv @@
// tshu_queue: two-entry op queue between front end and back end.
// Depends on tshu_pkg.
`default_nettype none

module tshu_queue import tshu_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_op       o_op
);

    t_op        r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_entry[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_op;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tshu_back.sv @@
// tshu_back: executes queued ops against the sample ring: writes adds,
// issues reads one sample per cycle while the output drains and drives
// the output register. Depends on tshu_pkg and tshu_ram.
`default_nettype none

module tshu_back import tshu_pkg::*; #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_op         i_q_op,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [31:0]      o_result_value,
    output logic [31:0]      o_window_base,
    output logic [31:0]      o_relative_time,
    output logic             o_wrapped,
    output logic             o_last
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(RING_DEPTH);

    // read stage
    logic          r_s1_valid;
    logic          r_s1_first;
    logic          r_s1_last;
    logic          r_s1_dump;
    logic [FW-1:0] r_idx;
    logic [31:0]   r_base;

    // output register
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [31:0]   r_value;
    logic [31:0]   r_base_out;
    logic [31:0]   r_rel;
    logic          r_wrap;
    logic          r_last;

    logic          out_free;
    logic          s1_adv;
    logic          s1_free;
    logic          is_rd;
    logic          launch;
    logic          direct;
    logic          last_launch;
    logic [SW-1:0] addr_sum;
    logic [AW-1:0] rd_addr;
    logic          ram_we;
    logic [63:0]   ram_rdata;
    logic [31:0]   base_now;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free;
    assign s1_free  = !r_s1_valid || s1_adv;
    assign is_rd    = (i_q_op.kind == OP_READ) || (i_q_op.kind == OP_DUMP);

    // reads advance as long as the read stage can drain
    assign launch      = i_q_valid && is_rd && s1_free;
    assign last_launch = ((r_idx + 1'b1) == i_q_op.count[FW-1:0]);
    // adds and status results wait for the read stage to empty
    assign direct      = i_q_valid && !is_rd && !r_s1_valid && out_free;
    assign ram_we      = direct && (i_q_op.kind == OP_ADD);
    assign o_pop       = direct || (launch && last_launch);

    // address of the current sample, modulo ring depth
    assign addr_sum = SW'(i_q_op.addr[AW-1:0]) + SW'(r_idx);
    assign rd_addr  = (addr_sum >= DEPTH_S) ? AW'(addr_sum - DEPTH_S) : AW'(addr_sum);

    tshu_ram #(
        .WIDTH (64),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_op.addr[AW-1:0]),
        .i_wdata ({i_q_op.stamp, i_q_op.value}),
        .i_re    (launch),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // oldest sample of a dump sets the base time
    assign base_now = r_s1_first ? ram_rdata[63:32] : r_base;

    // sample index and read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (launch) begin
                r_idx      <= last_launch ? '0 : r_idx + 1'b1;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // read stage tags
    always_ff @(posedge i_clk) begin
        if (launch) begin
            r_s1_first <= (r_idx == '0);
            r_s1_last  <= last_launch;
            r_s1_dump  <= (i_q_op.kind == OP_DUMP);
        end
        if (s1_adv && r_s1_first) begin
            r_base <= ram_rdata[63:32];
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv || direct) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_status   <= ST_OK;
            r_value    <= ram_rdata[31:0];
            r_base_out <= r_s1_dump ? base_now : 32'd0;
            r_rel      <= r_s1_dump ? (ram_rdata[63:32] - base_now) : 32'd0;
            r_wrap     <= 1'b0;
            r_last     <= r_s1_last;
        end else if (direct) begin
            r_status   <= i_q_op.status;
            r_value    <= 32'd0;
            r_base_out <= 32'd0;
            r_rel      <= 32'd0;
            r_wrap     <= (i_q_op.kind == OP_ADD) && i_q_op.wrap;
            r_last     <= 1'b1;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_result_value  = r_value;
    assign o_window_base   = r_base_out;
    assign o_relative_time = r_rel;
    assign o_wrapped       = r_wrap;
    assign o_last          = r_last;

endmodule

`default_nettype wire

@@ rtl/core/timestamped_sample_history_unit.sv @@
// timestamped_sample_history_unit: top level of the timestamped sample ring.
// Depends on tshu_pkg, tshu_front, tshu_queue, tshu_back (and tshu_ram).
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   input    | i_valid / o_stall     | command, value_kind, sample_value,
//            |                       | timestamp, count_requested
//   result   | o_valid / i_stall     | status, result_value, window_base,
//            |                       | relative_time, wrapped, last
//   config   | i_cfg_we              | i_cfg_wdata (value kind setting)
//
// Add and status items go straight to the output register; an add or status item right
// behind a read or dump waits for the read stage to empty. A dump of m samples makes
// one ring read per sample on the single read port. A read result passes the ring read
// register, then the output register, once its op reaches the back end. Reset clears
// pointers, fill level, queue and config; ring contents stay undefined, no clearing pass.
// The two-entry op queue lets each side stall alone.
`default_nettype none

module timestamped_sample_history_unit import tshu_pkg::*; #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic        i_value_kind,
    input  wire logic [31:0] i_sample_value,
    input  wire logic [31:0] i_timestamp,
    input  wire logic [15:0] i_count_requested,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [31:0]      o_result_value,
    output logic [31:0]      o_window_base,
    output logic [31:0]      o_relative_time,
    output logic             o_wrapped,
    output logic             o_last
);

    logic q_full;
    logic push;
    t_op  push_op;
    logic q_valid;
    t_op  head_op;
    logic pop;

    // front end: accept and classify
    tshu_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_value_kind      (i_value_kind),
        .i_sample_value    (i_sample_value),
        .i_timestamp       (i_timestamp),
        .i_count_requested (i_count_requested),
        .i_q_full          (q_full),
        .o_push            (push),
        .o_op              (push_op)
    );

    // op queue
    tshu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    // back end: ring access and results
    tshu_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_op          (head_op),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_result_value  (o_result_value),
        .o_window_base   (o_window_base),
        .o_relative_time (o_relative_time),
        .o_wrapped       (o_wrapped),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire
